/* hw/rtl/pcd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_pkg: shared types and constants for the PNG chunk deframer
// Signature bytes, chunk type codes, event codes and the result record.
// ----------------------------------------------------------------------------
package pcd_pkg;

  // Chunk type codes, big-endian ASCII
  localparam logic [31:0] TypeIhdr = 32'h4948_4452;
  localparam logic [31:0] TypeIdat = 32'h4944_4154;
  localparam logic [31:0] TypeIend = 32'h4945_4E44;

  localparam int unsigned SigLen = 8;

  // Event codes carried on event_res
  typedef enum logic [1:0] {
    EvPayload = 2'd0,
    EvHeader  = 2'd1,
    EvEnd     = 2'd2,
    EvBadSig  = 2'd3
  } pcd_event_e;

  // One result item
  typedef struct packed {
    pcd_event_e  event_res;
    logic [7:0]  payload_byte;
    logic [30:0] image_width;
    logic [30:0] image_height;
    logic [7:0]  sample_depth;
    logic [7:0]  color_mode;
    logic [31:0] idat_bytes_total;
    logic [31:0] idat_chunk_count;
  } pcd_result_t;

  // Expected PNG file signature byte at a given position
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h89;
      3'd1:    val = 8'h50;
      3'd2:    val = 8'h4E;
      3'd3:    val = 8'h47;
      3'd4:    val = 8'h0D;
      3'd5:    val = 8'h0A;
      3'd6:    val = 8'h1A;
      3'd7:    val = 8'h0A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/png_chunk_deframer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// png_chunk_deframer_unit: streaming PNG signature check and chunk deframer
// Takes one file byte per transfer, passes IDAT data bytes on, and reports
// the image header, end of image and a bad signature as events.
// ----------------------------------------------------------------------------
//  Channel | Handshake              | Payload
//  --------+------------------------+---------------------------------------
//  in      | in_valid_i/in_ready_o  | data_byte_i, start_of_file_i
//  out     | out_valid_o/out_ready_i| event_res_o, payload_byte_o, header and
//          |                        | end-of-image fields
//
//  One byte per cycle while in_ready_o is high; a byte that causes a result
//  shows it on the outputs the cycle after its transfer.
//  The parse state updates in the transfer cycle; one result register sits
//  at the output.
//  in_ready_o drops only while a result is held and out_ready_i is low.
//  Reset puts the parser in the signature phase with all counts at zero.
// ----------------------------------------------------------------------------
module png_chunk_deframer_unit
  import pcd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        start_of_file_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       event_res_o,
  output logic [7:0]       payload_byte_o,
  output logic [30:0]      image_width_o,
  output logic [30:0]      image_height_o,
  output logic [7:0]       sample_depth_o,
  output logic [7:0]       color_mode_o,
  output logic [31:0]      idat_bytes_total_o,
  output logic [31:0]      idat_chunk_count_o
);

  logic        accept;
  logic        res_valid;
  logic        free;
  pcd_result_t res;
  pcd_result_t res_out;

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  pcd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .start_of_file_i (start_of_file_i),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  pcd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && res_valid),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .free_o      (free),
    .res_o       (res_out)
  );

  // Result fields to ports
  assign event_res_o        = res_out.event_res;
  assign payload_byte_o     = res_out.payload_byte;
  assign image_width_o      = res_out.image_width;
  assign image_height_o     = res_out.image_height;
  assign sample_depth_o     = res_out.sample_depth;
  assign color_mode_o       = res_out.color_mode;
  assign idat_bytes_total_o = res_out.idat_bytes_total;
  assign idat_chunk_count_o = res_out.idat_chunk_count;

endmodule
`default_nettype wire

/* hw/rtl/pcd_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_parser: byte-wise PNG signature and chunk walker
// Holds parse state, updates it once per accepted byte and forms at most
// one result for that byte.
// ----------------------------------------------------------------------------
module pcd_parser
  import pcd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        start_of_file_i,
  output logic             res_valid_o,
  output pcd_result_t      res_o
);

  typedef enum logic [2:0] {
    PhSig  = 3'd0,
    PhLen  = 3'd1,
    PhType = 3'd2,
    PhData = 3'd3,
    PhCrc  = 3'd4,
    PhDone = 3'd5,
    PhBad  = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d, phase_c;
  logic [31:0] cnt_q, cnt_d, cnt_c, cnt_inc;
  logic [31:0] len_q, len_d, len_c;
  logic [31:0] type_q, type_d, type_c;
  logic [30:0] width_q, width_d, width_c;
  logic [30:0] height_q, height_d, height_c;
  logic [7:0]  depth_q, depth_d, depth_c;
  logic [7:0]  colour_q, colour_d, colour_c;
  logic [31:0] sum_q, sum_d, sum_c;
  logic [31:0] count_q, count_d, count_c;
  logic [32:0] sum_ext;
  logic [31:0] type_shift;

  // Start of file restarts the parser before the byte is parsed
  always_comb begin
    if (start_of_file_i) begin
      phase_c  = PhSig;
      cnt_c    = '0;
      len_c    = '0;
      type_c   = '0;
      width_c  = '0;
      height_c = '0;
      depth_c  = '0;
      colour_c = '0;
      sum_c    = '0;
      count_c  = '0;
    end else begin
      phase_c  = phase_q;
      cnt_c    = cnt_q;
      len_c    = len_q;
      type_c   = type_q;
      width_c  = width_q;
      height_c = height_q;
      depth_c  = depth_q;
      colour_c = colour_q;
      sum_c    = sum_q;
      count_c  = count_q;
    end
  end

  assign cnt_inc    = cnt_c + 32'd1;
  assign type_shift = {type_c[23:0], data_byte_i};
  assign sum_ext    = {1'b0, sum_c} + {1'b0, len_c};

  // Next state and result for the current byte
  always_comb begin
    phase_d     = phase_c;
    cnt_d       = cnt_c;
    len_d       = len_c;
    type_d      = type_c;
    width_d     = width_c;
    height_d    = height_c;
    depth_d     = depth_c;
    colour_d    = colour_c;
    sum_d       = sum_c;
    count_d     = count_c;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_c)
      PhSig: begin
        if (data_byte_i != sig_byte(cnt_c[2:0])) begin
          phase_d         = PhBad;
          res_valid_o     = 1'b1;
          res_o.event_res = EvBadSig;
        end else if (cnt_c[2:0] == 3'(SigLen - 1)) begin
          phase_d = PhLen;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PhLen: begin
        len_d = {len_c[23:0], data_byte_i};
        if (cnt_c[1:0] == 2'd3) begin
          phase_d = PhType;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PhType: begin
        type_d = type_shift;
        if (cnt_c[1:0] != 2'd3) begin
          cnt_d = cnt_inc;
        end else begin
          cnt_d = '0;
          if (type_shift == TypeIend) begin
            phase_d                = PhDone;
            res_valid_o            = 1'b1;
            res_o.event_res        = EvEnd;
            res_o.idat_bytes_total = sum_c;
            res_o.idat_chunk_count = count_c;
          end else begin
            if (type_shift == TypeIdat) begin
              if (count_c != '1) begin
                count_d = count_c + 32'd1;
              end
              sum_d = sum_ext[32] ? '1 : sum_ext[31:0];
            end
            if (type_shift == TypeIhdr) begin
              width_d  = '0;
              height_d = '0;
              depth_d  = '0;
              colour_d = '0;
            end
            if (len_c == '0) begin
              phase_d = PhCrc;
              // zero-length header chunk reports cleared fields
              if (type_shift == TypeIhdr) begin
                res_valid_o     = 1'b1;
                res_o.event_res = EvHeader;
              end
            end else begin
              phase_d = PhData;
            end
          end
        end
      end
      PhData: begin
        if (type_c == TypeIhdr) begin
          if (cnt_c < 32'd4) begin
            width_d = {width_c[22:0], data_byte_i};
          end else if (cnt_c < 32'd8) begin
            height_d = {height_c[22:0], data_byte_i};
          end else if (cnt_c == 32'd8) begin
            depth_d = data_byte_i;
          end else if (cnt_c == 32'd9) begin
            colour_d = data_byte_i;
          end
        end else if (type_c == TypeIdat) begin
          res_valid_o        = 1'b1;
          res_o.event_res    = EvPayload;
          res_o.payload_byte = data_byte_i;
        end
        if (cnt_inc == len_c) begin
          phase_d = PhCrc;
          cnt_d   = '0;
          if (type_c == TypeIhdr) begin
            res_valid_o = 1'b1;
            res_o.event_res    = EvHeader;
            res_o.image_width  = width_d;
            res_o.image_height = height_d;
            res_o.sample_depth = depth_d;
            res_o.color_mode   = colour_d;
          end
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PhCrc: begin
        if (cnt_c[1:0] == 2'd3) begin
          phase_d = PhLen;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: begin
        // done, bad signature and unused codes: byte ignored
      end
    endcase
  end

  // Parse state, updated on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSig;
      cnt_q    <= '0;
      len_q    <= '0;
      type_q   <= '0;
      width_q  <= '0;
      height_q <= '0;
      depth_q  <= '0;
      colour_q <= '0;
      sum_q    <= '0;
      count_q  <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      type_q   <= type_d;
      width_q  <= width_d;
      height_q <= height_d;
      depth_q  <= depth_d;
      colour_q <= colour_d;
      sum_q    <= sum_d;
      count_q  <= count_d;
    end
  end

  // A bad signature report leaves the parser in the bad-signature phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && res_valid_o && res_o.event_res == EvBadSig) |=> (phase_q == PhBad))
    else $error("bad signature did not park the parser");

  // After end of image, bytes without a start flag produce nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDone && !start_of_file_i) |-> !res_valid_o)
    else $error("result produced after end of image");

  // Inside chunk data the byte index stays below the chunk length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (cnt_q < len_q))
    else $error("data byte index overran chunk length");

endmodule
`default_nettype wire

/* hw/rtl/pcd_out_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_out_reg: result register for the PNG chunk deframer
// Holds one result until the downstream side takes it; refills in the
// same cycle the held result leaves.
// ----------------------------------------------------------------------------
module pcd_out_reg
  import pcd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         load_i,
  input  wire pcd_result_t  res_i,
  input  wire logic         out_ready_i,
  output logic              out_valid_o,
  output logic              free_o,
  output pcd_result_t       res_o
);

  logic        valid_q, valid_d;
  pcd_result_t res_q;

  // Register can take a new result if empty or draining this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  // A load never lands on a held result that is not leaving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result overwritten before transfer");

  // Held result leaves only through a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> (valid_q && res_q == $past(res_q)))
    else $error("held result changed or dropped without transfer");

  // Without a load the register empties after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_ready_i && !load_i) |=> !valid_q)
    else $error("result repeated after transfer");

endmodule
`default_nettype wire

/* test/png_chunk_deframer_unit_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// png_chunk_deframer_unit_tb: self-checking bench for the PNG chunk deframer
// Feeds byte streams built as PNG files (clean, truncated, bad signature and
// noise) and predicts every payload, header, end-of-image and bad-signature event in the
// bench. Each output transfer is checked field by field against the oldest
// prediction, under random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module png_chunk_deframer_unit_tb
  import pcd_pkg::*;
;

  // Parser phases of the predictor
  typedef enum logic [2:0] {
    PhSig  = 3'd0,
    PhLen  = 3'd1,
    PhType = 3'd2,
    PhData = 3'd3,
    PhCrc  = 3'd4,
    PhDone = 3'd5,
    PhBad  = 3'd6
  } parse_phase_e;

  localparam logic [63:0] PngMagic = 64'h8950_4E47_0D0A_1A0A;
  localparam int unsigned RunLimit = 400_000;
  localparam int unsigned DrainLimit = 20_000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        start_of_file_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  event_res_o;
  logic [7:0]  payload_byte_o;
  logic [30:0] image_width_o;
  logic [30:0] image_height_o;
  logic [7:0]  sample_depth_o;
  logic [7:0]  color_mode_o;
  logic [31:0] idat_bytes_total_o;
  logic [31:0] idat_chunk_count_o;

  png_chunk_deframer_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .start_of_file_i    (start_of_file_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .event_res_o        (event_res_o),
    .payload_byte_o     (payload_byte_o),
    .image_width_o      (image_width_o),
    .image_height_o     (image_height_o),
    .sample_depth_o     (sample_depth_o),
    .color_mode_o       (color_mode_o),
    .idat_bytes_total_o (idat_bytes_total_o),
    .idat_chunk_count_o (idat_chunk_count_o)
  );

  // Idle rates in percent, and the output hold-off counter
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_left;

  // Run statistics
  int unsigned n_errors;
  int unsigned n_bytes;
  int unsigned n_payload;
  int unsigned n_headers;
  int unsigned n_ends;
  int unsigned n_badsig;

  // Parser state mirror
  parse_phase_e ph;
  logic [31:0]  fcnt;
  logic [31:0]  clen;
  logic [31:0]  ctype;
  logic [31:0]  hdr_w;
  logic [31:0]  hdr_h;
  logic [7:0]   hdr_depth;
  logic [7:0]   hdr_color;
  logic [31:0]  idat_total;
  logic [31:0]  idat_chunks;

  pcd_result_t events_q[$];
  logic [7:0]  file_q[$];

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #(RunLimit);
    $display("png_chunk_deframer_unit_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_parser();
    ph          = PhSig;
    fcnt        = '0;
    clen        = '0;
    ctype       = '0;
    hdr_w       = '0;
    hdr_h       = '0;
    hdr_depth   = '0;
    hdr_color   = '0;
    idat_total  = '0;
    idat_chunks = '0;
  endfunction

  function automatic pcd_result_t header_event();
    pcd_result_t r;
    r              = '0;
    r.event_res    = EvHeader;
    r.image_width  = hdr_w[30:0];
    r.image_height = hdr_h[30:0];
    r.sample_depth = hdr_depth;
    r.color_mode   = hdr_color;
    return r;
  endfunction

  // Advance the parser by one byte; queue the event it causes, if any
  function automatic void predict_byte(input logic [7:0] b, input logic sof);
    pcd_result_t r;
    logic        hit;
    int          sidx;
    r   = '0;
    hit = 1'b0;
    if (sof) clear_parser();
    case (ph)
      PhSig: begin
        sidx = 7 - int'(fcnt[2:0]);
        if (b != PngMagic[sidx*8 +: 8]) begin
          ph          = PhBad;
          r.event_res = EvBadSig;
          hit         = 1'b1;
        end else begin
          fcnt++;
          if (fcnt >= 8) begin
            ph   = PhLen;
            fcnt = '0;
          end
        end
      end
      PhLen: begin
        clen = {clen[23:0], b};
        fcnt++;
        if (fcnt >= 4) begin
          ph   = PhType;
          fcnt = '0;
        end
      end
      PhType: begin
        ctype = {ctype[23:0], b};
        fcnt++;
        if (fcnt >= 4) begin
          fcnt = '0;
          if (ctype == TypeIend) begin
            ph                 = PhDone;
            r.event_res        = EvEnd;
            r.idat_bytes_total = idat_total;
            r.idat_chunk_count = idat_chunks;
            hit                = 1'b1;
          end else begin
            if (ctype == TypeIdat) begin
              if (idat_chunks != 32'hFFFF_FFFF) idat_chunks++;
              if (idat_total > 32'hFFFF_FFFF - clen) idat_total = 32'hFFFF_FFFF;
              else idat_total = idat_total + clen;
            end
            if (ctype == TypeIhdr) begin
              hdr_w     = '0;
              hdr_h     = '0;
              hdr_depth = '0;
              hdr_color = '0;
            end
            if (clen == 0) begin
              ph = PhCrc;
              if (ctype == TypeIhdr) begin
                r   = header_event();
                hit = 1'b1;
              end
            end else begin
              ph = PhData;
            end
          end
        end
      end
      PhData: begin
        if (ctype == TypeIhdr) begin
          if (fcnt < 4) hdr_w = {hdr_w[23:0], b};
          else if (fcnt < 8) hdr_h = {hdr_h[23:0], b};
          else if (fcnt == 8) hdr_depth = b;
          else if (fcnt == 9) hdr_color = b;
        end else if (ctype == TypeIdat) begin
          r.event_res    = EvPayload;
          r.payload_byte = b;
          hit            = 1'b1;
        end
        fcnt++;
        if (fcnt == clen) begin
          ph   = PhCrc;
          fcnt = '0;
          if (ctype == TypeIhdr) begin
            r   = header_event();
            hit = 1'b1;
          end
        end
      end
      PhCrc: begin
        fcnt++;
        if (fcnt >= 4) begin
          ph   = PhLen;
          fcnt = '0;
        end
      end
      default: ;
    endcase
    if (hit) events_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: ready generation and result check
  // ---------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  initial begin
    pcd_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        case (event_res_o)
          EvPayload: n_payload++;
          EvHeader:  n_headers++;
          EvEnd:     n_ends++;
          default:   n_badsig++;
        endcase
        if (events_q.size() == 0) begin
          $error("result transfer with nothing pending, event %0d", event_res_o);
          n_errors++;
        end else begin
          want = events_q.pop_front();
          check_field("event_res", 32'(want.event_res), 32'(event_res_o));
          check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte_o));
          check_field("image_width", 32'(want.image_width), 32'(image_width_o));
          check_field("image_height", 32'(want.image_height), 32'(image_height_o));
          check_field("sample_depth", 32'(want.sample_depth), 32'(sample_depth_o));
          check_field("color_mode", 32'(want.color_mode), 32'(color_mode_o));
          check_field("idat_bytes_total", want.idat_bytes_total, idat_bytes_total_o);
          check_field("idat_chunk_count", want.idat_chunk_count, idat_chunk_count_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: byte transfer and file building
  // ---------------------------------------------------------------------------
  // Called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic sof);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    data_byte_i     = b;
    start_of_file_i = sof;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_byte(b, sof);
    n_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_file(input logic with_sof);
    foreach (file_q[i]) send_byte(file_q[i], with_sof && (i == 0));
    file_q.delete();
    in_valid_i = 1'b0;
  endtask

  function automatic void add_u32(input logic [31:0] v);
    for (int i = 3; i >= 0; i--) file_q.push_back(v[i*8 +: 8]);
  endfunction

  function automatic void add_random(input int unsigned n);
    repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_magic();
    add_u32(PngMagic[63:32]);
    add_u32(PngMagic[31:0]);
  endfunction

  // Chunk with random data and CRC
  function automatic void add_chunk(input logic [31:0] typ, input int unsigned len);
    add_u32(len);
    add_u32(typ);
    add_random(len + 4);
  endfunction

  // IHDR with the given length field; data beyond the 13 header bytes is random
  function automatic void add_ihdr(input int unsigned len, input logic [31:0] w,
                                   input logic [31:0] h, input logic [7:0] d,
                                   input logic [7:0] c);
    logic [103:0] hdr;
    hdr = {w, h, d, c, 24'($urandom)};
    add_u32(len);
    add_u32(TypeIhdr);
    for (int unsigned i = 0; i < len; i++) begin
      if (i < 13) file_q.push_back(hdr[(12 - i)*8 +: 8]);
      else file_q.push_back(8'($urandom_range(0, 255)));
    end
    add_random(4);
  endfunction

  function automatic logic [31:0] other_type();
    logic [31:0] t;
    t = $urandom;
    while (t == TypeIhdr || t == TypeIdat || t == TypeIend) t = $urandom;
    return t;
  endfunction

  function automatic logic [31:0] rand_dim();
    case ($urandom_range(0, 3))
      0:       return 32'hFFFF_FFFF;
      1:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Well-formed file with random content into file_q
  function automatic void build_png();
    int unsigned len;
    add_magic();
    if ($urandom_range(0, 9) != 0) begin
      len = ($urandom_range(0, 9) < 7) ? 13 : $urandom_range(0, 20);
      add_ihdr(len, rand_dim(), rand_dim(), 8'($urandom), 8'($urandom));
    end
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
          add_chunk(TypeIdat, len);
        end
        6: add_ihdr(13, rand_dim(), rand_dim(), 8'($urandom), 8'($urandom));
        default: add_chunk(other_type(), $urandom_range(0, 12));
      endcase
    end
    add_chunk(TypeIend, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0);
    if ($urandom_range(0, 4) == 0) add_random($urandom_range(1, 3));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // First file after reset comes without a start flag
  task automatic test_no_start_flag();
    add_magic();
    add_chunk(TypeIdat, 0);
    add_chunk(TypeIend, 0);
    send_file(1'b0);
  endtask

  // Mismatch on the first and on the last signature byte, tail ignored
  task automatic test_bad_signature();
    add_u32(32'h0050_4E47);
    add_u32(32'h0D0A_1A0A);
    add_random(3);
    send_file(1'b1);
    add_u32(PngMagic[63:32]);
    add_u32(32'h0D0A_1AFF);
    add_random(3);
    send_file(1'b1);
  endtask

  // Full, empty, short, long and repeated IHDR; IDAT extremes; trailing bytes
  task automatic test_header_cases();
    add_magic();
    add_ihdr(13, 32'hFFFF_FFFF, 32'h8000_0001, 8'hFF, 8'h00);
    add_ihdr(0, '0, '0, '0, '0);
    add_ihdr(5, 32'h1234_5678, 32'hA5A5_A5A5, 8'h08, 8'h06);
    add_ihdr(20, '0, 32'h7FFF_FFFF, 8'h00, 8'hFF);
    add_chunk(other_type(), 3);
    add_u32(2);
    add_u32(TypeIdat);
    file_q.push_back(8'h00);
    file_q.push_back(8'hFF);
    add_random(4);
    add_chunk(TypeIdat, 0);
    add_chunk(TypeIend, 4);
    add_random(2);
    send_file(1'b1);
  endtask

  // Start flag in the middle of an IDAT with the largest length
  task automatic test_restart();
    add_magic();
    add_u32(32'hFFFF_FFFF);
    add_u32(TypeIdat);
    add_random(5);
    send_file(1'b1);
    add_magic();
    add_chunk(TypeIdat, 3);
    add_chunk(TypeIend, 0);
    send_file(1'b1);
  endtask

  // Long output hold-off while the input keeps offering payload bytes
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_left    = 300;
    add_magic();
    add_chunk(TypeIdat, 60);
    add_chunk(TypeIend, 0);
    send_file(1'b1);
  endtask

  task automatic test_random_files(input int unsigned target, input int unsigned s_idle,
                                   input int unsigned r_idle);
    int unsigned goal;
    int unsigned cut;
    int unsigned pos;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    goal = n_bytes + target;
    while (n_bytes < goal) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          // truncated file; a later file restarts the parser only if it has a start flag
          build_png();
          cut = $urandom_range(1, file_q.size() - 1);
          repeat (cut) void'(file_q.pop_back());
          send_file(1'b1);
        end
        3, 4: begin
          // one signature byte corrupted
          add_magic();
          pos = $urandom_range(0, 7);
          file_q[pos] = file_q[pos] ^ 8'($urandom_range(1, 255));
          add_random($urandom_range(0, 10));
          send_file(1'b1);
        end
        5: begin
          add_random($urandom_range(1, 8));
          send_file($urandom_range(0, 3) == 0);
        end
        default: begin
          build_png();
          send_file($urandom_range(0, 19) != 0);
        end
      endcase
    end
  endtask

  task automatic finish_run();
    int unsigned guard;
    guard = 0;
    while (events_q.size() != 0 && guard < DrainLimit) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (8) @(negedge clk_i);
    if (events_q.size() != 0) begin
      $error("%0d predicted results never arrived", events_q.size());
      n_errors++;
    end
    $display("Sent %0d file bytes; checked %0d payload bytes, %0d headers,",
             n_bytes, n_payload, n_headers);
    $display("%0d end-of-image and %0d bad-signature events.", n_ends, n_badsig);
    if (n_errors == 0) begin
      $display("png_chunk_deframer_unit_tb: done, clean");
    end else begin
      $display("png_chunk_deframer_unit_tb: done, errors");
    end
    $finish;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = '0;
    start_of_file_i = 1'b0;
    send_idle_pct   = 31;
    recv_idle_pct   = 82;
    stall_left      = 0;
    n_errors        = 0;
    n_bytes         = 0;
    n_payload       = 0;
    n_headers       = 0;
    n_ends          = 0;
    n_badsig        = 0;
    clear_parser();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_no_start_flag();
    test_bad_signature();
    test_header_cases();
    test_restart();
    test_backpressure();
    test_random_files(700, 31, 82);
    test_random_files(700, 82, 31);
    test_random_files(700, 0, 0);
    finish_run();
  end

endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/pcd_pkg.sv
hw/rtl/pcd_parser.sv
hw/rtl/pcd_out_reg.sv
hw/rtl/png_chunk_deframer_unit.sv
test/png_chunk_deframer_unit_tb.sv
